### hw/rtl/bkrf_pkg.sv
package bkrf_pkg;

	localparam int unsigned BTN_W   = 32;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned DELAY_W = 24;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned IDX_W   = 3;

	// Register index, taken from paddr[4:2]
	typedef enum logic [IDX_W-1:0] {
		REG_REPEAT_MASK = 3'd0,
		REG_NORMAL_MASK = 3'd1,
		REG_TOGGLE_MASK = 3'd2,
		REG_START_DELAY = 3'd3,
		REG_NEXT_DELAY  = 3'd4
	} reg_idx_t;

	// Input action codes
	typedef enum logic {
		ACT_PROCESS = 1'b0,
		ACT_RESET   = 1'b1
	} action_t;

endpackage

### hw/rtl/button_key_repeat_filter.sv
// Typematic key-repeat filter for a 32-bit button bitmap. Each accepted item
// (action, buttons_in, timestamp) yields exactly one result item
// (filtered_buttons, raw_buttons). An item is registered at the input, worked
// through combinational compare-and-mask logic against the repeat state, and
// lands in an output register; out_valid rises once the input-stage item moves
// into the output register, which waits while out_stall holds it full, and one
// item is taken every cycle as long as out_stall stays low.
// The repeat state (last tick, last pattern, suppressed buttons, repeating
// flag) is fed back and updated as each item advances. A reset action records
// the held normal buttons and suppresses them until the held normal pattern
// changes; a new nonzero pattern passes whole and restarts timing; a held
// pattern passes only toggle buttons until start_delay ticks pass, then emits
// its repeat buttons once per delay (next_delay after the first repeat). Tick
// differences wrap modulo 2^32. Registers sit on an APB port at byte address
// 4*i: repeat_mask (0x00, a write of zero is ignored), normal_mask (0x04),
// toggle_mask (0x08), start_delay (0x0C, 24 bits), next_delay (0x10, 24 bits).
// Write registers only while no item is in flight.
module button_key_repeat_filter (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [bkrf_pkg::BTN_W-1:0]    buttons_in,
	input  logic [bkrf_pkg::TICK_W-1:0]   timestamp,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bkrf_pkg::BTN_W-1:0]    filtered_buttons,
	output logic [bkrf_pkg::BTN_W-1:0]    raw_buttons,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bkrf_pkg::ADDR_W-1:0]   paddr,
	input  logic [bkrf_pkg::DATA_W-1:0]   pwdata,
	output logic [bkrf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	// Configuration registers
	logic [bkrf_pkg::BTN_W-1:0]   repeat_mask_q;
	logic [bkrf_pkg::BTN_W-1:0]   normal_mask_q;
	logic [bkrf_pkg::BTN_W-1:0]   toggle_mask_q;
	logic [bkrf_pkg::DELAY_W-1:0] start_delay_q;
	logic [bkrf_pkg::DELAY_W-1:0] next_delay_q;

	// Repeat state
	logic [bkrf_pkg::TICK_W-1:0]  last_tick_q;
	logic [bkrf_pkg::BTN_W-1:0]   last_pattern_q;
	logic [bkrf_pkg::BTN_W-1:0]   pre_pressed_q;
	logic                         repeating_q;

	// Input stage
	logic                         valid_s1;
	bkrf_pkg::action_t            action_s1;
	logic [bkrf_pkg::BTN_W-1:0]   buttons_s1;
	logic [bkrf_pkg::TICK_W-1:0]  timestamp_s1;

	// Output stage
	logic                         out_valid_q;
	logic [bkrf_pkg::BTN_W-1:0]   filtered_q;
	logic [bkrf_pkg::BTN_W-1:0]   raw_q;

	logic                         out_free;
	logic                         advance;
	logic                         in_take;

	logic                         cfg_write;
	bkrf_pkg::reg_idx_t           cfg_idx;

	logic                         sup_hit;
	logic [bkrf_pkg::BTN_W-1:0]   b_sup;
	logic [bkrf_pkg::DELAY_W-1:0] delay;
	logic [bkrf_pkg::TICK_W-1:0]  elapsed;
	logic                         fire;
	logic                         same_pat;

	logic [bkrf_pkg::BTN_W-1:0]   filt_next;
	logic [bkrf_pkg::TICK_W-1:0]  last_tick_next;
	logic [bkrf_pkg::BTN_W-1:0]   last_pattern_next;
	logic [bkrf_pkg::BTN_W-1:0]   pre_pressed_next;
	logic                         repeating_next;

	// ---------------------------------------------------------------
	// Handshake: the output register frees when empty or being taken;
	// the input stage moves on whenever the output register frees.
	// ---------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign out_valid        = out_valid_q;
	assign filtered_buttons = filtered_q;
	assign raw_buttons      = raw_q;

	// ---------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = bkrf_pkg::reg_idx_t'(paddr[bkrf_pkg::ADDR_W-1:2]);

	always_comb begin
		case (cfg_idx)
			bkrf_pkg::REG_REPEAT_MASK: prdata = repeat_mask_q;
			bkrf_pkg::REG_NORMAL_MASK: prdata = normal_mask_q;
			bkrf_pkg::REG_TOGGLE_MASK: prdata = toggle_mask_q;
			bkrf_pkg::REG_START_DELAY: prdata = {{(bkrf_pkg::DATA_W-bkrf_pkg::DELAY_W){1'b0}},
			                                     start_delay_q};
			bkrf_pkg::REG_NEXT_DELAY:  prdata = {{(bkrf_pkg::DATA_W-bkrf_pkg::DELAY_W){1'b0}},
			                                     next_delay_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_mask_q <= '0;
			normal_mask_q <= '0;
			toggle_mask_q <= '0;
			start_delay_q <= '0;
			next_delay_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_idx)
				bkrf_pkg::REG_REPEAT_MASK: begin
					// A zero mask would silence all repeats; keep the old one.
					if (pwdata != '0) repeat_mask_q <= pwdata;
				end
				bkrf_pkg::REG_NORMAL_MASK: normal_mask_q <= pwdata;
				bkrf_pkg::REG_TOGGLE_MASK: toggle_mask_q <= pwdata;
				bkrf_pkg::REG_START_DELAY: start_delay_q <= pwdata[bkrf_pkg::DELAY_W-1:0];
				bkrf_pkg::REG_NEXT_DELAY:  next_delay_q  <= pwdata[bkrf_pkg::DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Filter logic on the input stage
	// ---------------------------------------------------------------
	// Drop the held normal buttons while exactly that pattern stays down.
	assign sup_hit = (pre_pressed_q != '0) && (pre_pressed_q == (buttons_s1 & normal_mask_q));
	assign b_sup   = sup_hit ? (buttons_s1 & ~normal_mask_q) : buttons_s1;

	assign delay    = repeating_q ? next_delay_q : start_delay_q;
	assign elapsed  = timestamp_s1 - last_tick_q;
	assign fire     = elapsed >= {{(bkrf_pkg::TICK_W-bkrf_pkg::DELAY_W){1'b0}}, delay};
	assign same_pat = b_sup == last_pattern_q;

	always_comb begin
		filt_next         = b_sup;
		last_tick_next    = last_tick_q;
		last_pattern_next = last_pattern_q;
		repeating_next    = repeating_q;
		// Once the held pattern breaks, suppression is off for good.
		pre_pressed_next  = sup_hit ? pre_pressed_q : '0;

		if (action_s1 == bkrf_pkg::ACT_RESET) begin
			filt_next         = '0;
			last_tick_next    = '0;
			last_pattern_next = buttons_s1;
			pre_pressed_next  = buttons_s1 & normal_mask_q;
			repeating_next    = 1'b0;
		end else if (b_sup != '0) begin
			if (same_pat) begin
				if (fire) begin
					last_tick_next = timestamp_s1;
					repeating_next = 1'b1;
					filt_next      = b_sup & repeat_mask_q;
				end else begin
					filt_next      = b_sup & toggle_mask_q;
				end
			end else begin
				// New pattern: pass it whole and restart timing.
				last_tick_next    = timestamp_s1;
				last_pattern_next = b_sup;
				repeating_next    = 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			last_tick_q    <= '0;
			last_pattern_q <= '0;
			pre_pressed_q  <= '0;
			repeating_q    <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (out_free) begin
				out_valid_q <= valid_s1;
			end

			if (advance) begin
				last_tick_q    <= last_tick_next;
				last_pattern_q <= last_pattern_next;
				pre_pressed_q  <= pre_pressed_next;
				repeating_q    <= repeating_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1    <= bkrf_pkg::action_t'(action);
			buttons_s1   <= buttons_in;
			timestamp_s1 <= timestamp;
		end
		if (advance) begin
			filtered_q <= filt_next;
			raw_q      <= buttons_s1;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("item moved on but output register is empty");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pre_pressed_q) && $stable(last_tick_q) && $stable(repeating_q))
		else $error("repeat state changed without an item");

	a_repeat_rises_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(repeating_q) |-> $past(advance && fire && same_pat))
		else $error("repeating set without a timed repeat");

endmodule
